// ===== hdl/assert_macros.svh =====
// Assertion macros for the generator's top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property checked on every rising clock edge outside reset.
`define CMWC_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("cmwc assertion failed");

// A consequent that must hold in the cycle after its antecedent.
`define CMWC_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cmwc assertion failed");

`endif

// ===== hdl/cmwc_pkg.sv =====
// Types and constants shared by the multiply-with-carry generator.
`timescale 1ns / 1ps
package cmwc_pkg;

   localparam int WORD_W       = 32;
   localparam int CARRY_W      = 30;
   localparam int LOAD_INDEX_W = 12;
   localparam int KIND_W       = 2;
   localparam int MULT_W       = 15;
   localparam int PROD_W       = WORD_W + MULT_W;
   localparam int REQ_DATA_W   = 48;

   localparam logic [MULT_W-1:0]  MULTIPLIER        = 15'd18782;
   localparam logic [WORD_W-1:0]  COMPLEMENT_BASE   = 32'hffff_fffe;
   localparam logic [CARRY_W-1:0] CARRY_LIMIT_RESET = 30'd809430660;

   localparam logic [KIND_W-1:0] KIND_LOAD_WORD  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_LOAD_CARRY = 2'd1;
   localparam logic [KIND_W-1:0] KIND_GENERATE   = 2'd2;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      OP_LOAD_WORD,
      OP_LOAD_CARRY,
      OP_GENERATE
   } op_type;

   typedef struct packed {
      op_type                  op;
      logic [LOAD_INDEX_W-1:0] index;
      logic [WORD_W-1:0]       value;
   } cmd_type;

   typedef struct packed {
      logic [QUEUE_CNT_W-1:0] count;
      logic                   full;
      logic                   empty;
   } queue_status_type;

endpackage

// ===== hdl/cmwc_queue.sv =====
// Short command queue between the request front end and the execution back end.
`timescale 1ns / 1ps
module cmwc_queue
   import cmwc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  cmd_type          push_data,
   input  logic             pop,
   output logic             head_valid,
   output cmd_type          head_data,
   output queue_status_type status
);

   cmd_type                entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   do_push, do_pop;

   always_comb begin
      do_push   = push && (count_ff != QUEUE_CNT_W'(QUEUE_DEPTH));
      do_pop    = pop && (count_ff != '0);
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head_valid   = (count_ff != '0);
   assign head_data    = entry_ff[rd_ptr_ff];
   assign status.count = count_ff;
   assign status.full  = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

// ===== hdl/cmwc_front.sv =====
// Request front end: accepts requests, decodes their kind and saturates carry loads.
`timescale 1ns / 1ps
module cmwc_front
   import cmwc_pkg::*;
#(
   parameter int LAG_LENGTH = 4096
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CARRY_W-1:0]    csr_wr_data,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [KIND_W-1:0]     req_tuser,
   input  logic                  queue_full,
   output logic                  push,
   output cmd_type               push_data
);

   localparam int RANGE_W = 17;

   logic [CARRY_W-1:0]      carry_limit_ff;
   logic [LOAD_INDEX_W-1:0] load_index;
   logic [WORD_W-1:0]       load_value;
   logic [CARRY_W-1:0]      carry_sat;
   logic                    index_ok;
   logic                    accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         carry_limit_ff <= CARRY_LIMIT_RESET;
      end else if (csr_wr_en) begin
         carry_limit_ff <= csr_wr_data;
      end
   end

   always_comb begin
      load_index = req_tdata[LOAD_INDEX_W-1:0];
      load_value = req_tdata[LOAD_INDEX_W +: WORD_W];
      accept     = req_tvalid && req_tready;
      index_ok   = RANGE_W'(load_index) < RANGE_W'(LAG_LENGTH);

      if (carry_limit_ff == '0) begin
         carry_sat = '0;
      end else if (load_value >= WORD_W'(carry_limit_ff)) begin
         carry_sat = carry_limit_ff - 1'b1;
      end else begin
         carry_sat = load_value[CARRY_W-1:0];
      end

      push            = 1'b0;
      push_data.op    = OP_GENERATE;
      push_data.index = load_index;
      push_data.value = load_value;
      case (req_tuser)
         KIND_LOAD_WORD: begin
            push_data.op = OP_LOAD_WORD;
            push         = accept && index_ok;
         end
         KIND_LOAD_CARRY: begin
            push_data.op    = OP_LOAD_CARRY;
            push_data.value = WORD_W'(carry_sat);
            push            = accept;
         end
         KIND_GENERATE: begin
            push_data.op = OP_GENERATE;
            push         = accept;
         end
         default: begin
            push = 1'b0;
         end
      endcase
   end

   assign req_tready = !queue_full;

endmodule

// ===== hdl/cmwc_back.sv =====
// Execution back end: lag table, multiply-with-carry pipeline and response register.
`timescale 1ns / 1ps
module cmwc_back
   import cmwc_pkg::*;
#(
   parameter int LAG_LENGTH = 4096
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  cmd_type           head_data,
   output logic              pop,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [WORD_W-1:0] rsp_tdata
);

   localparam int PW    = $clog2(LAG_LENGTH);
   localparam int EXT_W = (PW > LOAD_INDEX_W) ? PW : LOAD_INDEX_W;
   localparam logic [PW-1:0] LAST_POS = PW'(LAG_LENGTH - 1);

   logic [WORD_W-1:0] mem [LAG_LENGTH];

   logic [PW-1:0]      pos_ff, pos_in;
   logic [CARRY_W-1:0] carry_ff, carry_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]  rsp_data_ff;

   logic               s1_valid_ff;
   op_type             s1_op_ff;
   logic [PW-1:0]      s1_addr_ff, s1_addr_in;
   logic [WORD_W-1:0]  s1_value_ff;
   logic [WORD_W-1:0]  rd_data_ff;

   logic               s2_valid_ff;
   op_type             s2_op_ff;
   logic [PW-1:0]      s2_addr_ff;
   logic [WORD_W-1:0]  s2_value_ff;
   logic [PROD_W-1:0]  s2_prod_ff, s2_prod_in;

   logic               adv, issue, hazard, head_gen, s1_wr, s2_wr;
   logic [PW-1:0]      pos_next, load_addr;
   logic [EXT_W-1:0]   index_ext;
   logic [PROD_W-1:0]  t_sum;
   logic [MULT_W-1:0]  carry_hi;
   logic [WORD_W:0]    low_sum;
   logic               wrap;
   logic [WORD_W-1:0]  x_word, out_word;

   always_comb begin
      adv       = !rsp_valid_ff || rsp_tready;
      pos_next  = (pos_ff == LAST_POS) ? '0 : pos_ff + 1'b1;
      index_ext = EXT_W'(head_data.index);
      load_addr = index_ext[PW-1:0];
      head_gen  = (head_data.op == OP_GENERATE);
      s1_wr     = (s1_op_ff == OP_LOAD_WORD) || (s1_op_ff == OP_GENERATE);
      s2_wr     = (s2_op_ff == OP_LOAD_WORD) || (s2_op_ff == OP_GENERATE);
      hazard    = head_gen &&
                  ((s1_valid_ff && s1_wr && (s1_addr_ff == pos_next)) ||
                   (s2_valid_ff && s2_wr && (s2_addr_ff == pos_next)));
      issue     = head_valid && adv && !hazard;

      pos_in     = pos_ff;
      s1_addr_in = load_addr;
      if (issue) begin
         case (head_data.op)
            OP_GENERATE: begin
               pos_in     = pos_next;
               s1_addr_in = pos_next;
            end
            OP_LOAD_CARRY: begin
               pos_in = LAST_POS;
            end
            default: begin
               pos_in = pos_ff;
            end
         endcase
      end

      s2_prod_in = PROD_W'(rd_data_ff) * PROD_W'(MULTIPLIER);

      t_sum    = s2_prod_ff + PROD_W'(carry_ff);
      carry_hi = t_sum[PROD_W-1:WORD_W];
      low_sum  = {1'b0, t_sum[WORD_W-1:0]} + (WORD_W + 1)'(carry_hi);
      wrap     = low_sum[WORD_W];
      x_word   = low_sum[WORD_W-1:0] + WORD_W'(wrap);
      out_word = COMPLEMENT_BASE - x_word;

      carry_in = carry_ff;
      if (s2_valid_ff) begin
         case (s2_op_ff)
            OP_GENERATE:   carry_in = CARRY_W'(carry_hi) + CARRY_W'(wrap);
            OP_LOAD_CARRY: carry_in = s2_value_ff[CARRY_W-1:0];
            default:       carry_in = carry_ff;
         endcase
      end
      rsp_valid_in = s2_valid_ff && (s2_op_ff == OP_GENERATE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= LAST_POS;
         carry_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
      end else if (adv) begin
         pos_ff       <= pos_in;
         carry_ff     <= carry_in;
         rsp_valid_ff <= rsp_valid_in;
         s1_valid_ff  <= issue;
         s2_valid_ff  <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_op_ff    <= head_data.op;
         s1_addr_ff  <= s1_addr_in;
         s1_value_ff <= head_data.value;
         s2_op_ff    <= s1_op_ff;
         s2_addr_ff  <= s1_addr_ff;
         s2_value_ff <= s1_value_ff;
         s2_prod_ff  <= s2_prod_in;
         if (rsp_valid_in) begin
            rsp_data_ff <= out_word;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (issue && head_gen) begin
         rd_data_ff <= mem[pos_next];
      end
   end

   always_ff @(posedge clock) begin
      if (adv && s2_valid_ff && s2_wr) begin
         mem[s2_addr_ff] <= (s2_op_ff == OP_GENERATE) ? out_word : s2_value_ff;
      end
   end

   assign pop        = issue;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== hdl/cmwc_random_generator.sv =====
// Top level of the complementary multiply-with-carry random word generator.
// Requests arrive on the req_ stream; req_tuser carries the kind: table word load,
// carry load (which also rewinds the table position) or generate. Only a generate
// request yields a response, one 32-bit word on the rsp_ stream. Loads are consumed
// silently, as are unused kinds and table loads beyond the table.
// A request enters a four-entry queue; the back end issues one request per cycle unless
// a response held by the receiver or a table hazard stalls it, reads the lag table (one
// read and one write port), multiplies the word read and folds in the carry, each in its
// own register stage, so generate requests sustain one word per cycle. The carry update
// is a loop through the carry register in the last stage. A generate request whose
// table word is still being written by one of the two requests ahead of it waits. The
// csr_ port writes the carry limit; the user must write it only while the block is
// idle, which the block itself does not enforce. Synchronous reset clears the queue and
// pipeline, zeroes the carry, sets the position to the last table entry and restores the
// carry limit; the table itself is not cleared and must be loaded before it is read.
// When the receiver holds rsp_tready low, the back end freezes with the response held,
// the queue fills and req_tready falls once it is full.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module cmwc_random_generator
   import cmwc_pkg::*;
#(
   parameter int LAG_LENGTH = 4096
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CARRY_W-1:0]    csr_wr_data,   // carry_limit
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,     // load_index[11:0], load_value[43:12]
   input  logic [KIND_W-1:0]     req_tuser,     // kind[1:0]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [WORD_W-1:0]     rsp_tdata      // random_word[31:0]
);

   logic             q_push, q_pop, q_head_valid;
   cmd_type          q_push_data, q_head_data;
   queue_status_type q_stat;

   cmwc_front #(
      .LAG_LENGTH(LAG_LENGTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .queue_full (q_stat.full),
      .push       (q_push),
      .push_data  (q_push_data)
   );

   cmwc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .head_valid(q_head_valid),
      .head_data (q_head_data),
      .status    (q_stat)
   );

   cmwc_back #(
      .LAG_LENGTH(LAG_LENGTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .head_valid(q_head_valid),
      .head_data (q_head_data),
      .pop       (q_pop),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   `CMWC_ASSERT_NEXT(a_queue_count_up, clock, reset, q_push && !q_pop, q_stat.count == $past(q_stat.count) + 1'b1)
   `CMWC_ASSERT(a_pop_not_empty, clock, reset, q_pop |-> !q_stat.empty)
   `CMWC_ASSERT(a_no_push_when_full, clock, reset, q_stat.full |-> !q_push)
   `CMWC_ASSERT(a_no_issue_on_stall, clock, reset, (rsp_tvalid && !rsp_tready) |-> !q_pop)

endmodule
